// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/hsv2rgb_pkg.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB converter.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W             = 13;
  localparam int CHAN_W            = 8;
  localparam int HUE_FRAC_BITS_DEF = 4;
  localparam int CHAN_MAX          = 255;
  localparam int SEXT_DEG          = 60;
  localparam int TURN_DEG          = 360;

  // floor(V * num / 2^F) never exceeds 255 * 255 * 60
  localparam int Y_W      = 22;
  localparam int P_PROD_W = 16;

  // x / 255 for x < 2^16 as (x * ceil(2^24 / 255)) >> 24
  localparam int P_SHIFT   = 24;
  localparam int P_RECIP_W = 17;
  localparam logic [P_RECIP_W-1:0] P_RECIP =
    P_RECIP_W'(((64'd1 << P_SHIFT) + 64'(CHAN_MAX) - 64'd1) / 64'(CHAN_MAX));

  // y / (255 * 60) for y < 2^22 as (y * ceil(2^36 / 15300)) >> 36
  localparam int QT_DIV     = CHAN_MAX * SEXT_DEG;
  localparam int QT_SHIFT   = 36;
  localparam int QT_RECIP_W = 23;
  localparam logic [QT_RECIP_W-1:0] QT_RECIP =
    QT_RECIP_W'(((64'd1 << QT_SHIFT) + 64'(QT_DIV) - 64'd1) / 64'(QT_DIV));

  typedef enum logic [2:0] {
    SEXT_R_TO_Y = 3'd0,
    SEXT_Y_TO_G = 3'd1,
    SEXT_G_TO_C = 3'd2,
    SEXT_C_TO_B = 3'd3,
    SEXT_B_TO_M = 3'd4,
    SEXT_M_TO_R = 3'd5
  } sextant_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

// ----- hw/rtl/hsv_to_rgb_converter.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to 8-bit RGB pixel converter, fully pipelined.
// ---------------------------------------------------------------------------
// Usage notes:
//  - Input channel hsv_valid / hsv_stall / hsv carries one pixel word: hue in
//    1/2^HUE_FRAC_BITS degree units, saturation and brightness as x/255.
//  - Output channel rgb_valid / rgb_stall / rgb carries one RGB word per pixel.
//  - A word moves on a rising edge with valid high and stall low.
//  - Throughput: one word per cycle, sustained while rgb_stall is low.
//  - Seven registered stages lie between input acceptance and rgb_valid:
//    hue wrap, sextant split, products, numerators, V scaling, division by
//    reciprocal, channel routing. The output stage is a register.
//  - Each stage holds its own valid bit; an empty stage fills even while the
//    output is stalled, so bubbles close up. hsv_stall rises only when all
//    seven stages are full and rgb_stall is high.
//  - Hues of a full turn or more are taken as zero; zero saturation gives
//    grey by the same arithmetic (p = q = t = brightness).
//  - Synchronous reset empties the pipeline; no word is in flight after it.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              hsv_valid,
  output logic              hsv_stall,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output hsv2rgb_pkg::rgb_t rgb
);

  localparam int REM_W = $clog2(hsv2rgb_pkg::SEXT_DEG << HUE_FRAC_BITS);

  // sector -> multiply
  logic                             sec_valid, sec_stall;
  hsv2rgb_pkg::sextant_t            sec_sext;
  logic [REM_W-1:0]                 sec_rem;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   sec_sat, sec_bri;

  // multiply -> scale
  logic                             mul_valid, mul_stall;
  hsv2rgb_pkg::sextant_t            mul_sext;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   mul_bri;
  logic [hsv2rgb_pkg::P_PROD_W-1:0] mul_p;
  logic [hsv2rgb_pkg::Y_W-1:0]      mul_q, mul_t;

  hsv2rgb_sector #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv_valid),
    .in_stall  (hsv_stall),
    .in_word   (hsv),
    .out_valid (sec_valid),
    .out_stall (sec_stall),
    .out_sext  (sec_sext),
    .out_rem   (sec_rem),
    .out_sat   (sec_sat),
    .out_bri   (sec_bri)
  );

  hsv2rgb_mult #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_valid),
    .in_stall  (sec_stall),
    .in_sext   (sec_sext),
    .in_rem    (sec_rem),
    .in_sat    (sec_sat),
    .in_bri    (sec_bri),
    .out_valid (mul_valid),
    .out_stall (mul_stall),
    .out_sext  (mul_sext),
    .out_bri   (mul_bri),
    .out_p     (mul_p),
    .out_q     (mul_q),
    .out_t     (mul_t)
  );

  // final two stages; rgb is driven straight from the output register
  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_stall  (mul_stall),
    .in_sext   (mul_sext),
    .in_bri    (mul_bri),
    .in_p      (mul_p),
    .in_q      (mul_q),
    .in_t      (mul_t),
    .out_valid (rgb_valid),
    .out_stall (rgb_stall),
    .out_word  (rgb)
  );

endmodule

// ----- hw/rtl/hsv2rgb_sector.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_sector
// Two stages: hue wrap at a full turn, then sextant and remainder in it.
// ---------------------------------------------------------------------------
module hsv2rgb_sector #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int REM_W = $clog2(hsv2rgb_pkg::SEXT_DEG << HUE_FRAC_BITS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hsv2rgb_pkg::hsv_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hsv2rgb_pkg::sextant_t             out_sext,
  output logic [REM_W-1:0]                  out_rem,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_sat,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]    out_bri
);

  localparam logic [31:0] SEXT_UNITS = 32'(hsv2rgb_pkg::SEXT_DEG) << HUE_FRAC_BITS;
  localparam logic [31:0] FULL_TURN  = 32'(hsv2rgb_pkg::TURN_DEG) << HUE_FRAC_BITS;
  localparam logic [31:0] BOUND_2    = SEXT_UNITS * 32'd2;
  localparam logic [31:0] BOUND_3    = SEXT_UNITS * 32'd3;
  localparam logic [31:0] BOUND_4    = SEXT_UNITS * 32'd4;
  localparam logic [31:0] BOUND_5    = SEXT_UNITS * 32'd5;

  logic                             wrap_valid;
  logic [hsv2rgb_pkg::HUE_W-1:0]    wrap_hue;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   wrap_sat;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   wrap_bri;
  logic                             wrap_adv;
  logic                             sect_adv;
  logic [31:0]                      hue_x;
  logic [31:0]                      base;
  logic [31:0]                      rem_full;
  hsv2rgb_pkg::sextant_t            sext_next;

  assign sect_adv = !out_valid || !out_stall;
  assign wrap_adv = !wrap_valid || sect_adv;
  assign in_stall = !wrap_adv;

  // stage 1: hue of a full turn or more folds to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_valid <= 1'b0;
    end else if (wrap_adv) begin
      wrap_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap_adv && in_valid) begin
      wrap_hue <= (32'(in_word.hue) >= FULL_TURN) ? '0 : in_word.hue;
      wrap_sat <= in_word.saturation;
      wrap_bri <= in_word.brightness;
    end
  end

  // stage 2: sextant by parallel compares, remainder by one subtract
  always_comb begin
    hue_x = 32'(wrap_hue);
    if (hue_x >= BOUND_5) begin
      sext_next = hsv2rgb_pkg::SEXT_M_TO_R;
      base      = BOUND_5;
    end else if (hue_x >= BOUND_4) begin
      sext_next = hsv2rgb_pkg::SEXT_B_TO_M;
      base      = BOUND_4;
    end else if (hue_x >= BOUND_3) begin
      sext_next = hsv2rgb_pkg::SEXT_C_TO_B;
      base      = BOUND_3;
    end else if (hue_x >= BOUND_2) begin
      sext_next = hsv2rgb_pkg::SEXT_G_TO_C;
      base      = BOUND_2;
    end else if (hue_x >= SEXT_UNITS) begin
      sext_next = hsv2rgb_pkg::SEXT_Y_TO_G;
      base      = SEXT_UNITS;
    end else begin
      sext_next = hsv2rgb_pkg::SEXT_R_TO_Y;
      base      = '0;
    end
    rem_full = hue_x - base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sect_adv) begin
      out_valid <= wrap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sect_adv && wrap_valid) begin
      out_sext <= sext_next;
      out_rem  <= rem_full[REM_W-1:0];
      out_sat  <= wrap_sat;
      out_bri  <= wrap_bri;
    end
  end

endmodule

// ----- hw/rtl/hsv2rgb_mult.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_mult
// Three stages forming the p, q and t numerators scaled by brightness.
// ---------------------------------------------------------------------------
module hsv2rgb_mult #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int REM_W = $clog2(hsv2rgb_pkg::SEXT_DEG << HUE_FRAC_BITS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hsv2rgb_pkg::sextant_t               in_sext,
  input  logic [REM_W-1:0]                    in_rem,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]      in_sat,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]      in_bri,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hsv2rgb_pkg::sextant_t               out_sext,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]      out_bri,
  output logic [hsv2rgb_pkg::P_PROD_W-1:0]    out_p,
  output logic [hsv2rgb_pkg::Y_W-1:0]         out_q,
  output logic [hsv2rgb_pkg::Y_W-1:0]         out_t
);

  localparam int SEXT_UNITS = hsv2rgb_pkg::SEXT_DEG << HUE_FRAC_BITS;
  localparam int DEN        = hsv2rgb_pkg::CHAN_MAX * SEXT_UNITS;
  localparam int DEN_W      = $clog2(DEN + 1);
  localparam int CREM_W     = $clog2(SEXT_UNITS + 1);
  localparam int SR_W       = hsv2rgb_pkg::CHAN_W + REM_W;
  localparam int SC_W       = hsv2rgb_pkg::CHAN_W + CREM_W;
  localparam int QP_W       = hsv2rgb_pkg::CHAN_W + DEN_W;

  logic                             prod_adv, num_adv, scl_adv;
  logic                             prod_valid, num_valid;
  hsv2rgb_pkg::sextant_t            prod_sext, num_sext;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   prod_bri, num_bri;
  logic [hsv2rgb_pkg::P_PROD_W-1:0] prod_p, num_p;
  logic [SR_W-1:0]                  prod_srem;
  logic [SC_W-1:0]                  prod_screm;
  logic [DEN_W-1:0]                 num_q, num_t;
  logic [CREM_W-1:0]                crem;
  logic [QP_W-1:0]                  q_full, t_full;

  assign scl_adv  = !out_valid || !out_stall;
  assign num_adv  = !num_valid || scl_adv;
  assign prod_adv = !prod_valid || num_adv;
  assign in_stall = !prod_adv;

  assign crem = CREM_W'(32'(SEXT_UNITS) - 32'(in_rem));

  // stage 1: S*rem, S*(W-rem) and V*(255-S)
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_adv) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv && in_valid) begin
      prod_srem  <= SR_W'(in_sat) * SR_W'(in_rem);
      prod_screm <= SC_W'(in_sat) * SC_W'(crem);
      prod_p     <= hsv2rgb_pkg::P_PROD_W'(in_bri) *
                    (hsv2rgb_pkg::P_PROD_W'(hsv2rgb_pkg::CHAN_MAX) -
                     hsv2rgb_pkg::P_PROD_W'(in_sat));
      prod_sext  <= in_sext;
      prod_bri   <= in_bri;
    end
  end

  // stage 2: numerators against 255*W, never negative
  always_ff @(posedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
    end else if (num_adv) begin
      num_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (num_adv && prod_valid) begin
      num_q    <= DEN_W'(DEN) - DEN_W'(prod_srem);
      num_t    <= DEN_W'(DEN) - DEN_W'(prod_screm);
      num_p    <= prod_p;
      num_sext <= prod_sext;
      num_bri  <= prod_bri;
    end
  end

  // stage 3: scale by V and drop the hue fraction bits
  assign q_full = QP_W'(num_bri) * QP_W'(num_q);
  assign t_full = QP_W'(num_bri) * QP_W'(num_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scl_adv) begin
      out_valid <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scl_adv && num_valid) begin
      out_q    <= hsv2rgb_pkg::Y_W'(q_full >> HUE_FRAC_BITS);
      out_t    <= hsv2rgb_pkg::Y_W'(t_full >> HUE_FRAC_BITS);
      out_p    <= num_p;
      out_sext <= num_sext;
      out_bri  <= num_bri;
    end
  end

endmodule

// ----- hw/rtl/hsv2rgb_scale.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_scale
// Constant division by reciprocal multiply, then routing to the channels.
// ---------------------------------------------------------------------------
module hsv2rgb_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hsv2rgb_pkg::sextant_t             in_sext,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]    in_bri,
  input  logic [hsv2rgb_pkg::P_PROD_W-1:0]  in_p,
  input  logic [hsv2rgb_pkg::Y_W-1:0]       in_q,
  input  logic [hsv2rgb_pkg::Y_W-1:0]       in_t,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hsv2rgb_pkg::rgb_t                 out_word
);

  localparam int PM_W = hsv2rgb_pkg::P_PROD_W + hsv2rgb_pkg::P_RECIP_W;
  localparam int QM_W = hsv2rgb_pkg::Y_W + hsv2rgb_pkg::QT_RECIP_W;

  logic                           quo_adv, rt_adv;
  logic                           quo_valid;
  hsv2rgb_pkg::sextant_t          quo_sext;
  logic [hsv2rgb_pkg::CHAN_W-1:0] quo_v, quo_p, quo_q, quo_t;
  logic [PM_W-1:0]                p_mul;
  logic [QM_W-1:0]                q_mul, t_mul;
  hsv2rgb_pkg::rgb_t              route;

  assign rt_adv   = !out_valid || !out_stall;
  assign quo_adv  = !quo_valid || rt_adv;
  assign in_stall = !quo_adv;

  assign p_mul = PM_W'(in_p) * PM_W'(hsv2rgb_pkg::P_RECIP);
  assign q_mul = QM_W'(in_q) * QM_W'(hsv2rgb_pkg::QT_RECIP);
  assign t_mul = QM_W'(in_t) * QM_W'(hsv2rgb_pkg::QT_RECIP);

  // stage 1: quotients, each known to fit in a byte
  always_ff @(posedge clk) begin
    if (rst) begin
      quo_valid <= 1'b0;
    end else if (quo_adv) begin
      quo_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quo_adv && in_valid) begin
      quo_p    <= p_mul[hsv2rgb_pkg::P_SHIFT +: hsv2rgb_pkg::CHAN_W];
      quo_q    <= q_mul[hsv2rgb_pkg::QT_SHIFT +: hsv2rgb_pkg::CHAN_W];
      quo_t    <= t_mul[hsv2rgb_pkg::QT_SHIFT +: hsv2rgb_pkg::CHAN_W];
      quo_v    <= in_bri;
      quo_sext <= in_sext;
    end
  end

  // stage 2: route V, P, Q, T by sextant
  always_comb begin
    case (quo_sext)
      hsv2rgb_pkg::SEXT_R_TO_Y: route = '{red: quo_v, green: quo_t, blue: quo_p};
      hsv2rgb_pkg::SEXT_Y_TO_G: route = '{red: quo_q, green: quo_v, blue: quo_p};
      hsv2rgb_pkg::SEXT_G_TO_C: route = '{red: quo_p, green: quo_v, blue: quo_t};
      hsv2rgb_pkg::SEXT_C_TO_B: route = '{red: quo_p, green: quo_q, blue: quo_v};
      hsv2rgb_pkg::SEXT_B_TO_M: route = '{red: quo_t, green: quo_p, blue: quo_v};
      hsv2rgb_pkg::SEXT_M_TO_R: route = '{red: quo_v, green: quo_p, blue: quo_q};
      default:                  route = '{red: quo_v, green: quo_p, blue: quo_q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rt_adv) begin
      out_valid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rt_adv && quo_valid) begin
      out_word <= route;
    end
  end

endmodule

// ----- hw/rtl/hsv2rgb_checker.sv -----
// ---------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks of the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv2rgb_checker (
  input logic              clk,
  input logic              rst,
  input logic              hsv_stall,
  input logic              rgb_valid,
  input logic              rgb_stall,
  input hsv2rgb_pkg::rgb_t rgb
);

  // a stalled output word stays put
  `ASSERT_NEXT(a_out_hold, clk, rst, rgb_valid && rgb_stall, rgb_valid && $stable(rgb), "rgb word changed under stall")

  // pipeline comes out of reset empty
  `ASSERT_IMPLY(a_reset_empty, clk, rst, $past(rst), !rgb_valid, "rgb_valid set right after reset")

  // input is back-pressured only by a full pipeline behind a stalled output
  `ASSERT_IMPLY(a_stall_cause, clk, rst, hsv_stall, rgb_valid && rgb_stall, "hsv_stall without output stall")

  // no back-pressure while the output register is empty
  `ASSERT_ALWAYS(a_empty_ready, clk, rst, rgb_valid || !hsv_stall, "hsv_stall with empty output")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

// ----- tb/hsv_to_rgb_converter_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking test of the HSV to RGB pixel converter. Each accepted pixel
// word is run through a behavioural colour model, and the expected RGB word
// is queued. Every RGB word that leaves the block is checked field by field
// against the oldest queued word. Directed pixels cover the channel
// extremes, the hue wrap at a full turn, grey and every sextant boundary.
// Random pixels follow with bursty input and a varying output stall pattern.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_test;
  import hsv2rgb_pkg::*;

  // Hue scaling at the default number of fraction bits
  localparam int HFB         = HUE_FRAC_BITS_DEF;
  localparam int SEXT_UNITS  = SEXT_DEG << HFB;  // hue units in one sextant
  localparam int FULL_TURN   = TURN_DEG << HFB;  // first hue that wraps to 0
  localparam int HUE_MAX     = (1 << HUE_W) - 1;
  localparam int LATENCY     = 7;
  localparam int CYCLE_LIMIT = 400000;

  // One pixel in flight: the input word and the colour it must give
  typedef struct {
    hsv_t px;
    rgb_t colour;
  } pending_t;

  logic clk = 1'b0;
  logic rst;
  logic hsv_valid;
  logic hsv_stall;
  hsv_t hsv;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  rgb_t rgb;

  pending_t pending_pixels[$];
  int       mismatches  = 0;
  int       cycle_count = 0;
  int       burst_left  = 0;
  bit       sender_idles   = 1'b1;
  bit       receiver_quiet = 1'b0;

  hsv_to_rgb_converter uut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Colour model. Exact integer arithmetic, truncated: p, q and t are the
  // usual HSV intermediates with the sextant fraction taken as rem / W.
  // -------------------------------------------------------------------------
  function automatic rgb_t predict_rgb(input hsv_t px);
    longint unsigned h, s, v, sext, rem, den, p, q, t, r, g, b;
    rgb_t c;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      // grey: all channels follow brightness
      r = v;
      g = v;
      b = v;
    end else begin
      if (h >= FULL_TURN) h = 0;  // a full turn or more reads as red
      sext = h / SEXT_UNITS;
      rem  = h % SEXT_UNITS;
      den  = CHAN_MAX * SEXT_UNITS;
      p = (v * (CHAN_MAX - s)) / CHAN_MAX;
      q = (v * (den - s * rem)) / den;
      t = (v * (den - s * (SEXT_UNITS - rem))) / den;
      case (sext[2:0])
        SEXT_R_TO_Y: begin r = v; g = t; b = p; end
        SEXT_Y_TO_G: begin r = q; g = v; b = p; end
        SEXT_G_TO_C: begin r = p; g = v; b = t; end
        SEXT_C_TO_B: begin r = p; g = q; b = v; end
        SEXT_B_TO_M: begin r = t; g = p; b = v; end
        default:     begin r = v; g = p; b = q; end
      endcase
    end
    c.red   = r[CHAN_W-1:0];
    c.green = g[CHAN_W-1:0];
    c.blue  = b[CHAN_W-1:0];
    return c;
  endfunction

  function automatic hsv_t pixel(input int h, input int s, input int v);
    hsv_t px;
    px.hue        = h[HUE_W-1:0];
    px.saturation = s[CHAN_W-1:0];
    px.brightness = v[CHAN_W-1:0];
    return px;
  endfunction

  // Channel value weighted towards the ends of its range
  function automatic int random_channel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return CHAN_MAX;
    return $urandom_range(0, CHAN_MAX);
  endfunction

  // Mostly in-range hues, some near sextant borders, some past a full turn
  function automatic hsv_t random_pixel();
    int pick, h;
    pick = $urandom_range(0, 9);
    if (pick <= 5)
      h = $urandom_range(0, FULL_TURN - 1);
    else if (pick <= 7)
      h = $urandom_range(0, HUE_MAX);
    else if (pick == 8)
      h = $urandom_range(0, 6) * SEXT_UNITS + $urandom_range(0, 4) - 2;
    else
      h = $urandom_range(FULL_TURN, HUE_MAX);
    if (h < 0) h = 0;
    if (h > HUE_MAX) h = HUE_MAX;
    return pixel(h, random_channel(), random_channel());
  endfunction

  // -------------------------------------------------------------------------
  // Mismatch reporting
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // -------------------------------------------------------------------------
  // Sender. Drives at the falling edge; a word stays put until the block
  // takes it. Between bursts the line goes idle for a random gap.
  // -------------------------------------------------------------------------
  task automatic send_pixel(input hsv_t px);
    int       gap;
    pending_t entry;
    if (sender_idles && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      hsv_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    hsv_valid <= 1'b1;
    hsv       <= px;
    do @(posedge clk); while (hsv_stall);
    entry.px     = px;
    entry.colour = predict_rgb(px);
    pending_pixels.push_back(entry);
    if (burst_left > 0) burst_left--;
  endtask

  // -------------------------------------------------------------------------
  // Receiver. Stall pattern changes mode every so often: free running,
  // light random, regular long stalls, heavy random.
  // -------------------------------------------------------------------------
  int stall_mode  = 0;
  int mode_left   = 0;
  int stall_phase = 0;

  always @(negedge clk) begin
    bit stall_next;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(0, 2) == 0);
      2:       stall_next = ((stall_phase % 16) < 9);
      default: stall_next = ($urandom_range(0, 3) != 0);
    endcase
    if (receiver_quiet) stall_next = 1'b0;
    rgb_stall <= stall_next;
  end

  // -------------------------------------------------------------------------
  // Checker: every word taken from the output is matched in order
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    pending_t want;
    if (!rst && rgb_valid && !rgb_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected rgb word %h", rgb));
      end else begin
        want = pending_pixels.pop_front();
        if (rgb.red !== want.colour.red)
          report_mismatch($sformatf("hsv %0d/%0d/%0d red %0d, want %0d",
            want.px.hue, want.px.saturation, want.px.brightness,
            rgb.red, want.colour.red));
        if (rgb.green !== want.colour.green)
          report_mismatch($sformatf("hsv %0d/%0d/%0d green %0d, want %0d",
            want.px.hue, want.px.saturation, want.px.brightness,
            rgb.green, want.colour.green));
        if (rgb.blue !== want.colour.blue)
          report_mismatch($sformatf("hsv %0d/%0d/%0d blue %0d, want %0d",
            want.px.hue, want.px.saturation, want.px.brightness,
            rgb.blue, want.colour.blue));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hsv_to_rgb_converter_test failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // all-zero and all-one fields, tiny and full channels
  task automatic test_channel_extremes();
    send_pixel(pixel(0, 0, 0));
    send_pixel(pixel(HUE_MAX, CHAN_MAX, CHAN_MAX));
    send_pixel(pixel(0, CHAN_MAX, CHAN_MAX));
    send_pixel(pixel(0, 1, 1));
    send_pixel(pixel(SEXT_UNITS / 2, CHAN_MAX, 0));
    send_pixel(pixel(SEXT_UNITS / 2, CHAN_MAX, 128));
  endtask

  // hues at and past a full turn behave as hue 0
  task automatic test_full_turn_wrap();
    send_pixel(pixel(FULL_TURN - 1, CHAN_MAX, CHAN_MAX));
    send_pixel(pixel(FULL_TURN, CHAN_MAX, CHAN_MAX));
    send_pixel(pixel(HUE_MAX, 200, 100));
    send_pixel(pixel(FULL_TURN, 128, 77));
  endtask

  // zero saturation gives grey whatever the hue
  task automatic test_grey();
    send_pixel(pixel(1234, 0, 77));
    send_pixel(pixel(HUE_MAX, 0, CHAN_MAX));
    send_pixel(pixel(FULL_TURN, 0, 1));
  endtask

  // first and last hue of each sextant
  task automatic test_every_sextant();
    for (int k = 0; k < 6; k++) begin
      send_pixel(pixel(k * SEXT_UNITS, 200, 230));
      send_pixel(pixel(k * SEXT_UNITS + SEXT_UNITS - 1, CHAN_MAX, CHAN_MAX));
    end
  endtask

  // bulk random pixels with bursty input and output stalls
  task automatic test_random_pixels();
    repeat (1400) send_pixel(random_pixel());
  endtask

  // full rate on both sides, then full rate in against a stalling output
  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_quiet = 1'b1;
    repeat (150) send_pixel(random_pixel());
    receiver_quiet = 1'b0;
    repeat (150) send_pixel(random_pixel());
    sender_idles = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    hsv_valid = 1'b0;
    hsv       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_channel_extremes();
    test_full_turn_wrap();
    test_grey();
    test_every_sextant();
    test_random_pixels();
    test_back_to_back();

    @(negedge clk);
    hsv_valid <= 1'b0;

    // drain, then give a stray extra word time to show up
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("hsv_to_rgb_converter_test passed");
    else
      $display("hsv_to_rgb_converter_test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_sector.sv
hw/rtl/hsv2rgb_mult.sv
hw/rtl/hsv2rgb_scale.sv
hw/rtl/hsv_to_rgb_converter.sv
hw/rtl/hsv2rgb_checker.sv
tb/hsv_to_rgb_converter_test.sv
